// ----- hdl/srtf_pkg.sv -----
package srtf_pkg;

	// Widths fixed by the payload fields
	localparam int unsigned ID_W   = 16;
	localparam int unsigned ARR_W  = 20;
	localparam int unsigned BUR_W  = 16;
	localparam int unsigned SUM_W  = 32;
	localparam int unsigned CNT_W  = 7;

	// Static part of one table entry
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [ARR_W-1:0] arrival;
		logic [BUR_W-1:0] burst;
	} info_t;

	// Candidate as seen by the selection compare
	typedef struct packed {
		logic [BUR_W-1:0] rem;
		logic [ARR_W-1:0] arrival;
		logic [BUR_W-1:0] burst;
		logic [ID_W-1:0]  id;
	} cand_t;

endpackage

// ----- hdl/srtf_table.sv -----
module srtf_table #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IW    = 6
) (
	input  logic                        clk,
	input  logic                        info_we,
	input  logic [IW-1:0]               info_waddr,
	input  srtf_pkg::info_t             info_wdata,
	input  logic                        rem_we,
	input  logic [IW-1:0]               rem_waddr,
	input  logic [srtf_pkg::BUR_W-1:0]  rem_wdata,
	input  logic [IW-1:0]               rd_addr,
	output srtf_pkg::info_t             rd_info,
	output logic [srtf_pkg::BUR_W-1:0]  rd_rem
);

	srtf_pkg::info_t            info_mem [DEPTH];
	logic [srtf_pkg::BUR_W-1:0] rem_mem  [DEPTH];

	// Write static fields on load
	always_ff @(posedge clk) begin
		if (info_we) begin
			info_mem[info_waddr] <= info_wdata;
		end
	end

	// Write remaining time on load or after a run slice
	always_ff @(posedge clk) begin
		if (rem_we) begin
			rem_mem[rem_waddr] <= rem_wdata;
		end
	end

	// Registered read, one entry a cycle
	always_ff @(posedge clk) begin
		rd_info <= info_mem[rd_addr];
		rd_rem  <= rem_mem[rd_addr];
	end

endmodule

// ----- hdl/srtf_cmp.sv -----
module srtf_cmp (
	input  srtf_pkg::cand_t a,
	input  srtf_pkg::cand_t b,
	output logic            better
);

	// Rank: remaining, then arrival, then burst, then identifier
	always_comb begin
		if (a.rem != b.rem) begin
			better = a.rem < b.rem;
		end else if (a.arrival != b.arrival) begin
			better = a.arrival < b.arrival;
		end else if (a.burst != b.burst) begin
			better = a.burst < b.burst;
		end else begin
			better = a.id < b.id;
		end
	end

endmodule

// ----- hdl/srtf_total_waiting_time.sv -----
// Preemptive shortest-remaining-time-first scheduler, total waiting time.
// Input channel: one process per beat, taken at a rising edge with start high
// and busy low. Each beat stores id, arrival and burst in the process table.
// A beat past MAX_PROCESSES entries is dropped and raises overflow. The beat
// with last_process high also starts simulation; busy stays high until the
// result goes out.
// Output channel: done is high for exactly one cycle with total_waiting,
// overflow and process_count; the receiver cannot stall it.
// Sequence after the final beat: one table sweep to set up, then per
// scheduling event (an arrival, a completion or an idle jump) one sweep
// through the table's single read port plus an update through DECIDE, RUN
// and SUM as the event needs; then the result is emitted.
// Reset clears the count, sums and sequencer; table contents are not cleared.
module srtf_total_waiting_time #(
	parameter int unsigned MAX_PROCESSES = 64,
	parameter int unsigned TIME_BITS     = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [srtf_pkg::ID_W-1:0]    process_id,
	input  logic [srtf_pkg::ARR_W-1:0]   arrival_time,
	input  logic [srtf_pkg::BUR_W-1:0]   burst_time,
	input  logic                         last_process,
	output logic                         done,
	output logic [srtf_pkg::SUM_W-1:0]   total_waiting,
	output logic                         overflow,
	output logic [srtf_pkg::CNT_W-1:0]   process_count
);

	localparam int unsigned IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int unsigned CW = $clog2(MAX_PROCESSES + 1);
	localparam int unsigned AW = (TIME_BITS < srtf_pkg::ARR_W) ? TIME_BITS : srtf_pkg::ARR_W;
	localparam logic [srtf_pkg::ARR_W-1:0] ARR_MASK =
		{srtf_pkg::ARR_W{1'b1}} >> (srtf_pkg::ARR_W - AW);
	localparam int unsigned TW = srtf_pkg::SUM_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_INIT   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_RUN    = 3'd4;
	localparam logic [2:0] ST_SUM    = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q, left_q, idx_q;
	logic          ovf_q;
	logic [TW-1:0] now_q, sum_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	srtf_pkg::cand_t best_q;
	logic [IW-1:0]   best_idx_q;
	logic            hb_q;
	logic [srtf_pkg::ARR_W-1:0] nxt_q;
	logic            hn_q;

	logic [IW-1:0]             cur_idx_q;
	logic [srtf_pkg::BUR_W-1:0] cur_rem_q;
	logic [srtf_pkg::ARR_W-1:0] cur_arr_q;
	logic [srtf_pkg::BUR_W-1:0] cur_bur_q;
	logic                      hc_q;

	logic                      done_q;
	logic [srtf_pkg::SUM_W-1:0] tw_q;
	logic                      ovo_q;
	logic [srtf_pkg::CNT_W-1:0] pc_q;

	// Table ports
	logic                       accept, room;
	logic                       rem_we;
	logic [IW-1:0]              rem_waddr;
	logic [srtf_pkg::BUR_W-1:0] rem_wdata;
	srtf_pkg::info_t            wr_info, rd_info;
	logic [srtf_pkg::BUR_W-1:0] rd_rem;
	srtf_pkg::cand_t            rd_cand;
	logic                       better;

	// Run slice arithmetic
	logic [TW-1:0]              arr_ext, nxt_ext, gap;
	logic [srtf_pkg::BUR_W-1:0] delta, rem_new;
	logic [TW-1:0]              wait_t;
	logic [TW:0]                sum_ext;
	logic [CW+srtf_pkg::CNT_W-1:0] cnt_wide;
	logic                       scanning, issue;

	assign accept = start && (state_q == ST_IDLE);
	assign room   = cnt_q < CW'(MAX_PROCESSES);
	assign busy   = state_q != ST_IDLE;

	assign wr_info.id      = process_id;
	assign wr_info.arrival = arrival_time & ARR_MASK;
	assign wr_info.burst   = burst_time;

	assign scanning = (state_q == ST_INIT) || (state_q == ST_SCAN);
	assign issue    = scanning && (idx_q < cnt_q);

	assign rd_cand.rem     = rd_rem;
	assign rd_cand.arrival = rd_info.arrival;
	assign rd_cand.burst   = rd_info.burst;
	assign rd_cand.id      = rd_info.id;

	assign arr_ext = TW'(rd_info.arrival);
	assign nxt_ext = TW'(nxt_q);
	assign gap     = nxt_ext - now_q;

	// Slice length: run to completion or to the next arrival
	always_comb begin
		delta = cur_rem_q;
		if (hn_q && (gap < TW'(cur_rem_q))) begin
			delta = gap[srtf_pkg::BUR_W-1:0];
		end
	end
	assign rem_new = cur_rem_q - delta;

	assign wait_t  = now_q - TW'(cur_arr_q) - TW'(cur_bur_q);
	assign sum_ext = {1'b0, sum_q} + {1'b0, wait_t};

	// Remaining-time write port: load beat or end of slice
	always_comb begin
		rem_we    = 1'b0;
		rem_waddr = cnt_q[IW-1:0];
		rem_wdata = burst_time;
		if (accept && room) begin
			rem_we = 1'b1;
		end else if (state_q == ST_RUN) begin
			rem_we    = 1'b1;
			rem_waddr = cur_idx_q;
			rem_wdata = rem_new;
		end
	end

	srtf_table #(
		.DEPTH (MAX_PROCESSES),
		.IW    (IW)
	) u_table (
		.clk        (clk),
		.info_we    (accept && room),
		.info_waddr (cnt_q[IW-1:0]),
		.info_wdata (wr_info),
		.rem_we     (rem_we),
		.rem_waddr  (rem_waddr),
		.rem_wdata  (rem_wdata),
		.rd_addr    (idx_q[IW-1:0]),
		.rd_info    (rd_info),
		.rd_rem     (rd_rem)
	);

	srtf_cmp u_cmp (
		.a      (rd_cand),
		.b      (best_q),
		.better (better)
	);

	assign cnt_wide = {{srtf_pkg::CNT_W{1'b0}}, cnt_q};

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			left_q  <= '0;
			idx_q   <= '0;
			ovf_q   <= 1'b0;
			now_q   <= '0;
			sum_q   <= '0;
			vld_s1  <= 1'b0;
			hb_q    <= 1'b0;
			hn_q    <= 1'b0;
			hc_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			// Pipeline the table sweep
			vld_s1 <= issue;
			idx_s1 <= idx_q[IW-1:0];
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_process) begin
							state_q <= ST_INIT;
							idx_q   <= '0;
							left_q  <= '0;
							hb_q    <= 1'b0;
							hc_q    <= 1'b0;
						end
					end
				end
				ST_INIT: begin
					// Count live entries, find earliest arrival
					if (vld_s1) begin
						if (rd_rem != '0) begin
							left_q <= left_q + CW'(1);
						end
						if (!hb_q || (arr_ext < now_q)) begin
							now_q <= arr_ext;
							hb_q  <= 1'b1;
						end
					end else if (!issue) begin
						state_q <= (left_q == '0) ? ST_FIN : ST_SCAN;
						idx_q   <= '0;
						hb_q    <= 1'b0;
						hn_q    <= 1'b0;
					end
				end
				ST_SCAN: begin
					// Pick best arrived entry, track next arrival
					if (vld_s1) begin
						if (rd_rem != '0) begin
							if (arr_ext <= now_q) begin
								if (!hb_q || better) begin
									best_q     <= rd_cand;
									best_idx_q <= idx_s1;
									hb_q       <= 1'b1;
								end
							end else if (!hn_q || (rd_info.arrival < nxt_q)) begin
								nxt_q <= rd_info.arrival;
								hn_q  <= 1'b1;
							end
						end
					end else if (!issue) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!hb_q) begin
						// Idle: jump to next arrival and sweep again
						now_q   <= nxt_ext;
						state_q <= ST_SCAN;
						idx_q   <= '0;
						hn_q    <= 1'b0;
					end else begin
						if (!hc_q || (best_q.rem < cur_rem_q)) begin
							cur_idx_q <= best_idx_q;
							cur_rem_q <= best_q.rem;
							cur_arr_q <= best_q.arrival;
							cur_bur_q <= best_q.burst;
							hc_q      <= 1'b1;
						end
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// Advance the clock by one slice
					now_q     <= now_q + TW'(delta);
					cur_rem_q <= rem_new;
					if (rem_new == '0) begin
						state_q <= ST_SUM;
					end else begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						hb_q    <= 1'b0;
						hn_q    <= 1'b0;
					end
				end
				ST_SUM: begin
					// Accumulate waiting time, saturate
					if (sum_ext[TW]) begin
						sum_q <= '1;
						ovf_q <= 1'b1;
					end else begin
						sum_q <= sum_ext[TW-1:0];
					end
					left_q  <= left_q - CW'(1);
					hc_q    <= 1'b0;
					state_q <= (left_q == CW'(1)) ? ST_FIN : ST_SCAN;
					idx_q   <= '0;
					hb_q    <= 1'b0;
					hn_q    <= 1'b0;
				end
				ST_FIN: begin
					// Emit result and clear batch state
					done_q  <= 1'b1;
					tw_q    <= sum_q;
					ovo_q   <= ovf_q;
					pc_q    <= cnt_wide[srtf_pkg::CNT_W-1:0];
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					sum_q   <= '0;
					now_q   <= '0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign total_waiting = tw_q;
	assign overflow      = ovo_q;
	assign process_count = pc_q;

endmodule

// ----- hdl/srtf_checker.sv -----
module srtf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        last_process,
	input logic        done,
	input logic [6:0]  process_count
);

	// A result beat comes only as the block goes idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// A plain load beat leaves the block idle in the next cycle
	a_load_one: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_process) |=> !busy) else $error("load stalled");

	// The final beat starts the simulation
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_process) |=> (busy && !done)) else $error("no run");

	// Strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("strobe held");

	// A batch holds at least one process
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (process_count != 7'd0)) else $error("empty batch");

endmodule

bind srtf_total_waiting_time srtf_checker u_srtf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.last_process  (last_process),
	.done          (done),
	.process_count (process_count)
);
